/* hdl/mcbrq_pkg.sv */
// Shared types and constants of the multi-channel byte ring queue.
package mcbrq_pkg;

	localparam int REG_COUNT = 4;
	localparam int REG_IDX_W = 2;
	localparam int DATA_W = 8;
	localparam int CHAN_W = 3;
	localparam logic [DATA_W-1:0] CAP_RESET = 8'd16;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BAD_CHAN = 2'd3
	} status_t;

	typedef struct packed {
		status_t status;
		logic    full;
		logic    empty;
		logic    wr_en;
		logic    rd_en;
	} step_res_t;

endpackage

/* hdl/mcbrq_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module mcbrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/mcbrq_ptr.sv */
// Capacity registers, head and tail pointers, and the per-beat push/pop decision.
module mcbrq_ptr import mcbrq_pkg::*; #(
	parameter int NUM_CHANNELS = 4,
	parameter int SLOTS_PER_CHANNEL = 256,
	parameter int ADDR_W = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata,
	input  logic                 step_en,
	input  op_t                  op,
	input  logic [CHAN_W-1:0]    channel,
	output step_res_t            res,
	output logic [ADDR_W-1:0]    addr
);

	localparam int PTR_W = (SLOTS_PER_CHANNEL > 1) ? $clog2(SLOTS_PER_CHANNEL) : 1;
	localparam int CAP_W = $clog2(SLOTS_PER_CHANNEL + 1);
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CMP_W = (CAP_W > DATA_W) ? CAP_W : DATA_W;

	logic [DATA_W-1:0] cap_q  [REG_COUNT];
	logic [PTR_W-1:0]  head_q [NUM_CHANNELS];
	logic [PTR_W-1:0]  tail_q [NUM_CHANNELS];

	logic              ch_ok;
	logic [CH_W-1:0]   ch_idx;
	logic [DATA_W-1:0] cap_raw;
	logic [CAP_W-1:0]  cap;
	logic [PTR_W-1:0]  head, tail, head_nxt, tail_nxt;
	logic              full_pre, empty_pre, push_ok, pop_ok;

	function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p,
			input logic [CAP_W-1:0] c);
		logic [CAP_W-1:0] p1;
		p1 = CAP_W'(p) + CAP_W'(1);
		return (p1 == c) ? '0 : PTR_W'(p1);
	endfunction

	always_comb begin
		ch_ok   = (channel != '0) && (channel <= CHAN_W'(NUM_CHANNELS));
		ch_idx  = CH_W'(channel - CHAN_W'(1));
		cap_raw = cap_q[REG_IDX_W'(ch_idx)];
		if (cap_raw == '0) begin
			cap = CAP_W'(1);
		end else if (CMP_W'(cap_raw) > CMP_W'(SLOTS_PER_CHANNEL)) begin
			cap = CAP_W'(SLOTS_PER_CHANNEL);
		end else begin
			cap = CAP_W'(cap_raw);
		end
		head      = head_q[ch_idx];
		tail      = tail_q[ch_idx];
		full_pre  = (ring_inc(tail, cap) == head);
		empty_pre = (head == tail);
		push_ok   = (op == OP_PUSH) && !full_pre;
		pop_ok    = (op == OP_POP) && !empty_pre;
		head_nxt  = pop_ok ? ring_inc(head, cap) : head;
		tail_nxt  = push_ok ? ring_inc(tail, cap) : tail;

		priority if (!ch_ok) begin
			res.status = ST_BAD_CHAN;
		end else if ((op == OP_PUSH) && !push_ok) begin
			res.status = ST_FULL;
		end else if ((op == OP_POP) && !pop_ok) begin
			res.status = ST_EMPTY;
		end else begin
			res.status = ST_OK;
		end
		res.full  = ch_ok && (ring_inc(tail_nxt, cap) == head_nxt);
		res.empty = ch_ok && (head_nxt == tail_nxt);
		res.wr_en = step_en && ch_ok && push_ok;
		res.rd_en = step_en && ch_ok && pop_ok;
		addr = ADDR_W'(ch_idx) * ADDR_W'(SLOTS_PER_CHANNEL)
			+ ADDR_W'((op == OP_PUSH) ? tail : head);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < REG_COUNT; r++) begin
				cap_q[r] <= CAP_RESET;
			end
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cap_q[cfg_index] <= cfg_wdata;
			end
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (cfg_we && (cfg_index == REG_IDX_W'(i))) begin
					head_q[i] <= '0;
					tail_q[i] <= '0;
				end else if (step_en && ch_ok && (ch_idx == CH_W'(i))) begin
					head_q[i] <= head_nxt;
					tail_q[i] <= tail_nxt;
				end
			end
		end
	end

endmodule

/* hdl/multi_channel_byte_ring_queue.sv */
// Top level of the multi-channel byte ring queue: store memory and result stage.
//
// Each beat on start pushes or pops one byte on one of the channels and gives
// exactly one result, strobed by done, in the cycle after the beat is taken.
// The block takes one beat per clock cycle and busy stays low: the pointers
// are updated at the edge that takes the beat, and the byte store is one
// memory with a single write port and a registered read port. The receiver
// cannot stall, so every result must be captured in the cycle that done is
// high. The user must write capacity registers only while no beat is
// outstanding; the block does not enforce it. A write empties that channel.
module multi_channel_byte_ring_queue import mcbrq_pkg::*; #(
	parameter int NUM_CHANNELS = 4,
	parameter int SLOTS_PER_CHANNEL = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [CHAN_W-1:0]    channel,
	input  logic [DATA_W-1:0]    push_byte,
	output logic                 done,
	output logic [1:0]           status,
	output logic [DATA_W-1:0]    pop_byte,
	output logic                 is_full,
	output logic                 is_empty
);

	localparam int DEPTH = NUM_CHANNELS * SLOTS_PER_CHANNEL;
	localparam int ADDR_W = $clog2(DEPTH);

	step_res_t         res;
	logic [ADDR_W-1:0] addr;
	logic [DATA_W-1:0] rdata;
	logic              step_en;

	logic    done_s1;
	status_t status_s1;
	logic    full_s1, empty_s1, popped_s1;

	assign busy    = 1'b0;
	assign step_en = start && !busy;

	mcbrq_ptr #(
		.NUM_CHANNELS      (NUM_CHANNELS),
		.SLOTS_PER_CHANNEL (SLOTS_PER_CHANNEL),
		.ADDR_W            (ADDR_W)
	) u_ptr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step_en   (step_en),
		.op        (op_t'(op)),
		.channel   (channel),
		.res       (res),
		.addr      (addr)
	);

	mcbrq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (res.wr_en),
		.waddr (addr),
		.wdata (push_byte),
		.re    (res.rd_en),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= step_en;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			status_s1 <= res.status;
			full_s1   <= res.full;
			empty_s1  <= res.empty;
			popped_s1 <= res.rd_en;
		end
	end

	assign done     = done_s1;
	assign status   = status_s1;
	assign pop_byte = popped_s1 ? rdata : '0;
	assign is_full  = full_s1;
	assign is_empty = empty_s1;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the multi-channel byte ring queue with its own queue predictor.
module testbench;
	import mcbrq_pkg::*;

	localparam int SLOTS = 256;
	localparam int CHANNELS = 4;
	localparam int PHASE_BEATS = 300;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		status_t     status;
		logic [7:0]  pop_byte;
		logic        is_full;
		logic        is_empty;
	} queue_result_t;

	class ring_queue_scoreboard;
		bit [7:0] ring_bytes [CHANNELS][SLOTS];
		bit [7:0] head_ptr [CHANNELS];
		bit [7:0] tail_ptr [CHANNELS];
		bit [7:0] capacity [REG_COUNT];
		queue_result_t expected_q [$];
		int unsigned errors;
		int unsigned beats;
		int unsigned status_seen [4];

		function new();
			foreach (capacity[i]) capacity[i] = CAP_RESET;
		endfunction

		function int ring_size(int c);
			int size;
			size = int'(capacity[c]);
			if (size == 0) size = 1;
			if (size > SLOTS) size = SLOTS;
			return size;
		endfunction

		function bit chan_full(int c);
			return ((int'(tail_ptr[c]) + 1) % ring_size(c)) == int'(head_ptr[c]);
		endfunction

		function bit chan_empty(int c);
			return head_ptr[c] == tail_ptr[c];
		endfunction

		function void write_capacity(int idx, logic [DATA_W-1:0] value);
			if (idx >= REG_COUNT) return;
			capacity[idx] = value;
			if (idx < CHANNELS) begin
				head_ptr[idx] = '0;
				tail_ptr[idx] = '0;
			end
		endfunction

		function void note_beat(op_t beat_op, logic [CHAN_W-1:0] chn, logic [7:0] data);
			queue_result_t res;
			int c;
			beats++;
			res = '{status: ST_OK, pop_byte: 8'd0, is_full: 1'b0, is_empty: 1'b0};
			if (chn == 0 || chn > CHANNELS) begin
				res.status = ST_BAD_CHAN;
				expected_q.push_back(res);
				return;
			end
			c = int'(chn) - 1;
			if (beat_op == OP_PUSH) begin
				if (chan_full(c)) begin
					res.status = ST_FULL;
				end else begin
					ring_bytes[c][tail_ptr[c]] = data;
					tail_ptr[c] = 8'((int'(tail_ptr[c]) + 1) % ring_size(c));
				end
			end else begin
				if (chan_empty(c)) begin
					res.status = ST_EMPTY;
				end else begin
					res.pop_byte = ring_bytes[c][head_ptr[c]];
					head_ptr[c] = 8'((int'(head_ptr[c]) + 1) % ring_size(c));
				end
			end
			res.is_full = chan_full(c);
			res.is_empty = chan_empty(c);
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [1:0] st, logic [7:0] data, logic full, logic empty);
			queue_result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("result beat with no request outstanding: status %0d", st);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			status_seen[exp_res.status]++;
			if (st !== exp_res.status) begin
				$error("status: expected %0d, got %0d", exp_res.status, st);
				errors++;
			end
			if (data !== exp_res.pop_byte) begin
				$error("pop_byte: expected %0h, got %0h", exp_res.pop_byte, data);
				errors++;
			end
			if (full !== exp_res.is_full) begin
				$error("is_full: expected %0b, got %0b", exp_res.is_full, full);
				errors++;
			end
			if (empty !== exp_res.is_empty) begin
				$error("is_empty: expected %0b, got %0b", exp_res.is_empty, empty);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic op = OP_PUSH;
	logic [CHAN_W-1:0] channel = '0;
	logic [DATA_W-1:0] push_byte = '0;
	logic done;
	logic [1:0] status;
	logic [DATA_W-1:0] pop_byte;
	logic is_full;
	logic is_empty;

	ring_queue_scoreboard sb = new();
	int unsigned setting_count = 0;

	multi_channel_byte_ring_queue u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.op(op),
		.channel(channel),
		.push_byte(push_byte),
		.done(done),
		.status(status),
		.pop_byte(pop_byte),
		.is_full(is_full),
		.is_empty(is_empty)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(status, pop_byte, is_full, is_empty);
			if (cfg_we) sb.write_capacity(int'(cfg_index), cfg_wdata);
			if (start && !busy) sb.note_beat(op_t'(op), channel, push_byte);
		end
	end

	task automatic send_beat(op_t beat_op, int chn, logic [7:0] data);
		start <= 1'b1;
		op <= beat_op;
		channel <= CHAN_W'(chn);
		push_byte <= data;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap();
		int n;
		case ($urandom_range(0, 19))
			0: n = $urandom_range(10, 40);
			1, 2, 3, 4, 5: n = $urandom_range(1, 3);
			default: n = 0;
		endcase
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_capacities(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3,
			logic [7:0] c4);
		logic [7:0] values [REG_COUNT];
		values = '{c1, c2, c3, c4};
		wait_drained();
		for (int i = 0; i < REG_COUNT; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_IDX_W'(i);
			cfg_wdata <= values[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	function automatic logic [7:0] pick_capacity();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd2;
			3: return 8'd3;
			4: return 8'd16;
			5: return 8'd255;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic run_random_phase(int n_beats);
		int sent;
		int len;
		int push_pct;
		int home;
		int chn;
		int pick;
		sent = 0;
		while (sent < n_beats) begin
			case ($urandom_range(0, 2))
				0: push_pct = 50;
				1: push_pct = 88;
				default: push_pct = 12;
			endcase
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 40);
			home = $urandom_range(1, CHANNELS);
			for (int k = 0; k < len && sent < n_beats; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					chn = home;
				end else if (pick < 92) begin
					chn = $urandom_range(1, CHANNELS);
				end else begin
					chn = $urandom_range(CHANNELS, 7);
					if (chn == CHANNELS) chn = 0;
				end
				send_beat(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, chn,
					8'($urandom_range(0, 255)));
				sent++;
				if ($urandom_range(0, 149) == 0) wait_drained();
				else idle_gap();
			end
		end
	endtask

	initial begin: stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bad channels, then pushes and pops at the default capacity.
		send_beat(OP_PUSH, 0, 8'hFF);
		send_beat(OP_POP, 7, 8'h00);
		send_beat(OP_PUSH, 5, 8'hA5);
		send_beat(OP_POP, 1, 8'h00);
		send_beat(OP_PUSH, 1, 8'h00);
		send_beat(OP_PUSH, 1, 8'hFF);
		send_beat(OP_PUSH, 4, 8'hA5);
		send_beat(OP_PUSH, 2, 8'h5A);
		send_beat(OP_POP, 1, 8'h00);
		send_beat(OP_POP, 1, 8'h00);
		send_beat(OP_POP, 1, 8'h00);
		send_beat(OP_POP, 4, 8'h00);
		send_beat(OP_POP, 2, 8'h00);

		// Zero capacity acts as one, capacity one refuses everything, capacity two holds a byte.
		write_capacities(8'd0, 8'd2, 8'd1, 8'd16);
		send_beat(OP_PUSH, 3, 8'h3C);
		send_beat(OP_POP, 3, 8'h00);
		send_beat(OP_PUSH, 1, 8'hC3);
		send_beat(OP_POP, 1, 8'h00);
		send_beat(OP_PUSH, 2, 8'h81);
		send_beat(OP_PUSH, 2, 8'h7E);
		send_beat(OP_POP, 2, 8'h00);
		send_beat(OP_POP, 2, 8'h00);

		run_random_phase(PHASE_BEATS);
		write_capacities(8'd1, 8'd2, 8'd255, 8'd0);
		run_random_phase(PHASE_BEATS);
		write_capacities(8'd255, 8'd0, 8'd1, 8'd2);
		run_random_phase(PHASE_BEATS);
		for (int p = 0; p < 3; p++) begin
			write_capacities(pick_capacity(), pick_capacity(), pick_capacity(),
				pick_capacity());
			run_random_phase(PHASE_BEATS);
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.pending() != 0) sb.errors++;
		$display("Covered %0d beats over %0d capacity settings.", sb.beats, setting_count);
		$display("Results: %0d ok, %0d full refusals, %0d empty refusals, %0d bad channel.",
			sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
			sb.status_seen[ST_BAD_CHAN]);
		if (sb.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	initial begin: watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped at the cycle limit with %0d results outstanding.", sb.pending());
		$display("testbench: errors");
		$finish;
	end

endmodule

/* filelist.f */
hdl/mcbrq_pkg.sv
hdl/mcbrq_ram.sv
hdl/mcbrq_ptr.sv
hdl/multi_channel_byte_ring_queue.sv
dv/testbench.sv
